// ===== design/dxtbd_pkg.sv =====
// Shared types, codes and constant dividers for the DXT block decoder.
`default_nettype none

package dxtbd_pkg;

	// Block layout selected by the format register.
	typedef enum logic [1:0] {
		FMT_DXT1  = 2'd0,
		FMT_DXT1A = 2'd1,
		FMT_DXT3  = 2'd2,
		FMT_DXT5  = 2'd3
	} fmt_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_FORMAT   = 1'b0,
		REG_RESTRICT = 1'b1
	} reg_idx_t;

	localparam int RESTRICT_W = 3;

	// Bits of the restriction register.
	localparam int RST_OPAQUE_ONLY = 0;
	localparam int RST_TRANSP_ONLY = 1;
	localparam int RST_COLOR_ORDER = 2;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
	} blk_in_t;

	typedef struct packed {
		chan_t       red;
		chan_t       green;
		chan_t       blue;
		chan_t       alpha;
		logic [3:0]  pixel_index;
		logic        last;
		logic        rejected;
	} pix_out_t;

	// Decoded block: palettes and the per-pixel code bits.
	typedef struct packed {
		logic              rejected;
		fmt_t              fmt;
		logic              four;
		logic [31:0]       indices;
		logic [63:0]       alpha_src;
		chan_t [3:0]       red;
		chan_t [3:0]       green;
		chan_t [3:0]       blue;
		chan_t [7:0]       apal;
	} blk_dec_t;

	// x / 3 for x <= 765 by reciprocal multiply.
	function automatic chan_t div3(input logic [9:0] x);
		logic [19:0] p;
		p = {10'd0, x} * 20'd683;
		return p[18:11];
	endfunction

	// x / 5 for x <= 1275.
	function automatic chan_t div5(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * 23'd3277;
		return p[21:14];
	endfunction

	// x / 7 for x <= 1785.
	function automatic chan_t div7(input logic [10:0] x);
		logic [22:0] p;
		p = {12'd0, x} * 23'd2341;
		return p[21:14];
	endfunction

endpackage

`default_nettype wire

// ===== design/dxtbd_decode.sv =====
// Block decode: endpoint expansion, colour and alpha palettes, restriction check.
`default_nettype none

module dxtbd_decode import dxtbd_pkg::*; (
	input  wire blk_in_t                 blk,
	input  wire fmt_t                    fmt,
	input  wire logic [RESTRICT_W-1:0]   mode_restrict,
	output blk_dec_t                     dec
);

	// (2a + b) / 3
	function automatic chan_t mix3(input chan_t a, input chan_t b);
		return div3({1'b0, a, 1'b0} + {2'b00, b});
	endfunction

	function automatic chan_t mean2(input chan_t a, input chan_t b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	logic        dxt1_kind;
	logic [63:0] src;
	logic [31:0] colors;
	logic        four;
	logic        use_four;
	logic        a_desc;
	chan_t       a0, a1;
	chan_t       r0, g0, b0, r1, g1, b1;

	always_comb begin
		dxt1_kind = (fmt == FMT_DXT1) || (fmt == FMT_DXT1A);
		src       = dxt1_kind ? blk.block_low : blk.block_high;
		colors    = src[31:0];
		four      = colors[15:0] > colors[31:16];
		use_four  = dxt1_kind ? four : 1'b1;

		// 565 expansion by plain shifts, no bit replication
		b0 = {colors[4:0], 3'b000};
		g0 = {colors[10:5], 2'b00};
		r0 = {colors[15:11], 3'b000};
		b1 = {colors[20:16], 3'b000};
		g1 = {colors[26:21], 2'b00};
		r1 = {colors[31:27], 3'b000};

		a0     = blk.block_low[7:0];
		a1     = blk.block_low[15:8];
		a_desc = a0 > a1;

		dec.fmt        = fmt;
		dec.four       = four;
		dec.indices    = src[63:32];
		dec.alpha_src  = blk.block_low;

		dec.red[0]   = r0;
		dec.green[0] = g0;
		dec.blue[0]  = b0;
		dec.red[1]   = r1;
		dec.green[1] = g1;
		dec.blue[1]  = b1;
		if (use_four) begin
			dec.red[2]   = mix3(r0, r1);
			dec.green[2] = mix3(g0, g1);
			dec.blue[2]  = mix3(b0, b1);
			dec.red[3]   = mix3(r1, r0);
			dec.green[3] = mix3(g1, g0);
			dec.blue[3]  = mix3(b1, b0);
		end else begin
			// three colours plus black
			dec.red[2]   = mean2(r0, r1);
			dec.green[2] = mean2(g0, g1);
			dec.blue[2]  = mean2(b0, b1);
			dec.red[3]   = '0;
			dec.green[3] = '0;
			dec.blue[3]  = '0;
		end

		// DXT5 alpha ramp: 8 levels when a0 > a1, else 6 plus 0 and 255
		dec.apal[0] = a0;
		dec.apal[1] = a1;
		for (int c = 2; c < 8; c++) begin
			if (a_desc) begin
				dec.apal[c] = div7(11'(8 - c) * {3'b000, a0} + 11'(c - 1) * {3'b000, a1});
			end else if (c < 6) begin
				dec.apal[c] = div5(11'(6 - c) * {3'b000, a0} + 11'(c - 1) * {3'b000, a1});
			end else if (c == 6) begin
				dec.apal[c] = 8'h00;
			end else begin
				dec.apal[c] = 8'hFF;
			end
		end

		case (fmt)
			FMT_DXT1A: begin
				dec.rejected = (four && mode_restrict[RST_TRANSP_ONLY])
					|| (!four && mode_restrict[RST_OPAQUE_ONLY]);
			end
			FMT_DXT3: begin
				dec.rejected = !four && mode_restrict[RST_COLOR_ORDER];
			end
			FMT_DXT5: begin
				dec.rejected = (a_desc && mode_restrict[RST_OPAQUE_ONLY])
					|| (!four && mode_restrict[RST_COLOR_ORDER]);
			end
			default: begin
				dec.rejected = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/dxt_block_decoder_unit.sv =====
// Top level of the DXT1/DXT1A/DXT3/DXT5 4x4 block decoder.
// An accepted block waits in the input holding register, is decoded into the emit stage, and
// its pixels pass the output register. Throughput: one pixel per cycle while out_ready holds, set
// by the pixel-select stage that walks one decoded block; the next block waits in the holding register.
// Reset (arst_n low, asynchronous) empties all stages and clears format and mode_restrict.
`default_nettype none

module dxt_block_decoder_unit import dxtbd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// block input
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire blk_in_t                 in_data,
	// pixel output
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output pix_out_t                     out_data,
	// configuration writes
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire reg_idx_t                cfg_index,
	input  wire logic [RESTRICT_W-1:0]   cfg_data
);

	// Configuration registers
	fmt_t                  fmt_q;
	logic [RESTRICT_W-1:0] restrict_q;

	// Input holding register: one block waiting for the emit stage
	blk_in_t  pend_q;
	logic     pend_valid_q;

	// Emit stage: decoded block plus pixel counter
	blk_dec_t cur_s1;
	logic     cur_valid_s1;
	logic [3:0] pix_q;

	// Output register
	pix_out_t out_q;
	logic     out_valid_q;

	blk_dec_t dec;
	logic     emit;
	logic     cur_done;
	logic     load;
	logic [1:0] sel;
	logic [5:0] code_off;
	logic [2:0] code;
	logic [3:0] nib;
	chan_t      alpha;
	pix_out_t   pix;

	dxtbd_decode u_decode (
		.blk           (pend_q),
		.fmt           (fmt_q),
		.mode_restrict (restrict_q),
		.dec           (dec)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = !pend_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A pixel moves into the output register when it is empty or being taken.
	assign emit     = cur_valid_s1 && (!out_valid_q || out_ready);
	// A rejected block gives its single result and is done.
	assign cur_done = emit && (cur_s1.rejected || pix_q == 4'd15);
	assign load     = pend_valid_q && (!cur_valid_s1 || cur_done);

	// Pixel select: palette entry, alpha source per format
	always_comb begin
		sel      = cur_s1.indices[{pix_q, 1'b0} +: 2];
		code_off = 6'd16 + 6'(pix_q) * 6'd3;
		code     = cur_s1.alpha_src[code_off +: 3];
		nib      = cur_s1.alpha_src[{pix_q, 2'b00} +: 4];

		case (cur_s1.fmt)
			FMT_DXT1:  alpha = 8'hFF;
			FMT_DXT1A: alpha = (!cur_s1.four && sel == 2'd3) ? 8'h00 : 8'hFF;
			FMT_DXT3:  alpha = {nib, nib}; // nibble * 17
			FMT_DXT5:  alpha = cur_s1.apal[code];
			default:   alpha = 8'hFF;
		endcase

		if (cur_s1.rejected) begin
			pix             = '0;
			pix.last        = 1'b1;
			pix.rejected    = 1'b1;
		end else begin
			pix.red         = cur_s1.red[sel];
			pix.green       = cur_s1.green[sel];
			pix.blue        = cur_s1.blue[sel];
			pix.alpha       = alpha;
			pix.pixel_index = pix_q;
			pix.last        = (pix_q == 4'd15);
			pix.rejected    = 1'b0;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q        <= FMT_DXT1;
			restrict_q   <= '0;
			pend_valid_q <= 1'b0;
			cur_valid_s1 <= 1'b0;
			pix_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FORMAT:   fmt_q      <= fmt_t'(cfg_data[1:0]);
					REG_RESTRICT: restrict_q <= cfg_data;
					default:      ;
				endcase
			end

			if (in_valid && in_ready) begin
				pend_valid_q <= 1'b1;
			end else if (load) begin
				pend_valid_q <= 1'b0;
			end

			if (load) begin
				cur_valid_s1 <= 1'b1;
			end else if (cur_done) begin
				cur_valid_s1 <= 1'b0;
			end

			if (emit) begin
				pix_q <= cur_done ? 4'd0 : pix_q + 4'd1;
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pend_q <= in_data;
		end
		if (load) begin
			cur_s1 <= dec;
		end
		if (emit) begin
			out_q <= pix;
		end
	end

endmodule

`default_nettype wire

// ===== design/dxtbd_checker.sv =====
// Port-level checks for the DXT block decoder, bound to the top level.
`default_nettype none

module dxtbd_checker import dxtbd_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire pix_out_t                out_data
);

	// Stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// Rejected block: one all-zero result that closes the block.
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rejected |-> out_data.last && out_data.pixel_index == 4'd0
			&& out_data.red == 8'd0 && out_data.green == 8'd0
			&& out_data.blue == 8'd0 && out_data.alpha == 8'd0)
		else $error("malformed rejected result");

	// Last marks exactly pixel 15 of a decoded block.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.rejected |-> out_data.last == (out_data.pixel_index == 4'd15))
		else $error("last on wrong pixel");

	// Pixels of a block follow one another without gaps.
	a_pix_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid
			&& out_data.pixel_index == 4'($past(out_data.pixel_index) + 4'd1))
		else $error("pixel sequence broken");

endmodule

bind dxt_block_decoder_unit dxtbd_checker u_dxtbd_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the DXT block decoder: directed and random blocks, all formats.
`timescale 1ns / 1ps

module tb;
	import dxtbd_pkg::*;

	// Endpoint words {colour1, colour0} and index words used by the directed blocks.
	localparam logic [31:0] COL_FOUR  = {16'h0000, 16'hFFFF};	// colour0 > colour1
	localparam logic [31:0] COL_THREE = {16'hFFFF, 16'h0000};	// colour0 <= colour1
	localparam logic [31:0] COL_MID   = 32'h1234ABCD;		// odd values, exercises truncation
	localparam logic [31:0] SEL_ALL   = 32'hE4E4E4E4;		// palette entries 0,1,2,3 repeating
	localparam logic [63:0] ONES      = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	blk_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_idx_t cfg_index = REG_FORMAT;
	logic [RESTRICT_W-1:0] cfg_data = '0;

	dxt_block_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Local copy of the two registers, updated when a write is accepted.
	fmt_t fmt_cfg = FMT_DXT1;
	logic [RESTRICT_W-1:0] rule_cfg = '0;

	blk_in_t block_q[$];		// blocks waiting for the driver
	pix_out_t pending_pixels[$];	// predicted pixels, oldest first

	int errors = 0;
	int blocks_added = 0;
	int blocks_in = 0;
	int blocks_refused = 0;
	int pixels_checked = 0;
	int reg_writes = 0;

	// Sender burst shaping.
	int burst_left = 1;
	int gap_left = 0;

	// Receiver stall pattern: a 16-bit mask rotated every cycle, reloaded whenever pat_age wraps to 0.
	// Every mask has at least one bit set, so no mask stalls the receiver for good.
	logic [15:0] ready_pat = '1;
	int pat_age = 0;

	// Expected pixels of one accepted block under the current register settings.
	function automatic void decode_block(blk_in_t blk);
		logic [63:0] word;
		logic [31:0] colors;
		logic [31:0] indices;
		logic dxt1_kind;
		logic four;
		logic reject;
		int a0;
		int a1;
		int pal [3][4];		// [red, green, blue][palette entry]
		int sel;
		int code;
		int alpha;
		pix_out_t px;

		dxt1_kind = (fmt_cfg == FMT_DXT1) || (fmt_cfg == FMT_DXT1A);
		// DXT1 kinds carry colour in the low half; DXT3/DXT5 in the high half.
		word = dxt1_kind ? blk.block_low : blk.block_high;
		colors = word[31:0];
		indices = word[63:32];
		four = colors[15:0] > colors[31:16];
		a0 = blk.block_low[7:0];
		a1 = blk.block_low[15:8];

		case (fmt_cfg)
		FMT_DXT1A: begin
			reject = four ? rule_cfg[RST_TRANSP_ONLY] : rule_cfg[RST_OPAQUE_ONLY];
		end
		FMT_DXT3: begin
			reject = !four && rule_cfg[RST_COLOR_ORDER];
		end
		FMT_DXT5: begin
			reject = (a0 > a1 && rule_cfg[RST_OPAQUE_ONLY]) ||
				(!four && rule_cfg[RST_COLOR_ORDER]);
		end
		default: begin
			reject = 1'b0;	// plain DXT1 ignores the restriction register
		end
		endcase

		if (reject) begin
			// Refused block: one zeroed item with rejected and last set.
			px = '0;
			px.last = 1'b1;
			px.rejected = 1'b1;
			pending_pixels.push_back(px);
			blocks_refused++;
			return;
		end

		// 565 endpoints expanded by plain shifts, no bit replication.
		pal[0][0] = {colors[15:11], 3'b000};
		pal[1][0] = {colors[10:5], 2'b00};
		pal[2][0] = {colors[4:0], 3'b000};
		pal[0][1] = {colors[31:27], 3'b000};
		pal[1][1] = {colors[26:21], 2'b00};
		pal[2][1] = {colors[20:16], 3'b000};
		for (int c = 0; c < 3; c++) begin
			if (!dxt1_kind || four) begin
				pal[c][2] = (2 * pal[c][0] + pal[c][1]) / 3;
				pal[c][3] = (pal[c][0] + 2 * pal[c][1]) / 3;
			end else begin
				// three-colour mode: mean and black
				pal[c][2] = (pal[c][0] + pal[c][1]) / 2;
				pal[c][3] = 0;
			end
		end

		for (int i = 0; i < 16; i++) begin
			sel = indices[2 * i +: 2];
			case (fmt_cfg)
			FMT_DXT1: begin
				alpha = 255;
			end
			FMT_DXT1A: begin
				alpha = (!four && sel == 3) ? 0 : 255;
			end
			FMT_DXT3: begin
				alpha = blk.block_low[4 * i +: 4] * 17;
			end
			default: begin
				// DXT5 ramp: 8 levels when a0 > a1, else 6 levels plus 0 and 255
				code = blk.block_low[16 + 3 * i +: 3];
				if (code == 0)
					alpha = a0;
				else if (code == 1)
					alpha = a1;
				else if (a0 > a1)
					alpha = ((8 - code) * a0 + (code - 1) * a1) / 7;
				else if (code == 6)
					alpha = 0;
				else if (code == 7)
					alpha = 255;
				else
					alpha = ((6 - code) * a0 + (code - 1) * a1) / 5;
			end
			endcase
			px.red = 8'(pal[0][sel]);
			px.green = 8'(pal[1][sel]);
			px.blue = 8'(pal[2][sel]);
			px.alpha = 8'(alpha);
			px.pixel_index = 4'(i);
			px.last = (i == 15);
			px.rejected = 1'b0;
			pending_pixels.push_back(px);
		end
	endfunction

	function automatic void check_field(string what, int pix, int want_v, int got_v);
		if (want_v != got_v) begin
			errors++;
			$display("%0t: pixel %0d %s expected %0d got %0d", $time, pix, what, want_v, got_v);
		end
	endfunction

	// Driver: bursts of blocks separated by random gaps. A new item is only
	// presented once the previous one was taken, so valid never drops early.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				decode_block(in_data);
				blocks_in++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (block_q.size() != 0) begin
					in_data <= block_q.pop_front();
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(20, 40) : $urandom_range(1, 8);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every accepted pixel and drives the receiver stall pattern.
	always @(posedge clk) begin
		pix_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					errors++;
					$display("%0t: pixel item %h arrived with none expected", $time, out_data);
				end else begin
					want = pending_pixels.pop_front();
					pixels_checked++;
					check_field("red", want.pixel_index, want.red, out_data.red);
					check_field("green", want.pixel_index, want.green, out_data.green);
					check_field("blue", want.pixel_index, want.blue, out_data.blue);
					check_field("alpha", want.pixel_index, want.alpha, out_data.alpha);
					check_field("pixel_index", want.pixel_index, want.pixel_index,
						out_data.pixel_index);
					check_field("last", want.pixel_index, want.last, out_data.last);
					check_field("rejected", want.pixel_index, want.rejected,
						out_data.rejected);
				end
			end
			if (pat_age == 0) begin
				case ($urandom_range(0, 2))
				0: ready_pat = '1;
				1: ready_pat = 16'($urandom) | 16'h0001;
				default: ready_pat = 16'h0001 << $urandom_range(0, 15);
				endcase
			end
			pat_age = (pat_age + 1) % 64;
			out_ready <= ready_pat[0];
			ready_pat = {ready_pat[0], ready_pat[15:1]};
		end
	end

	// One register write over the config channel; the local copy follows on acceptance.
	task automatic write_reg(reg_idx_t idx, logic [RESTRICT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_FORMAT)
			fmt_cfg = fmt_t'(val[1:0]);
		else
			rule_cfg = val;
		reg_writes++;
	endtask

	task automatic set_mode(logic [2:0] fmt_v, logic [2:0] rule_v);
		write_reg(REG_FORMAT, fmt_v);
		write_reg(REG_RESTRICT, rule_v);
	endtask

	// Wait until every queued block is accepted and every pixel is back, then let the pipe
	// settle. Acceptance and its predicted pixels are counted in the same step.
	task automatic drain();
		while (blocks_in != blocks_added || pending_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void add_block(logic [63:0] lo, logic [63:0] hi);
		block_q.push_back({lo, hi});
		blocks_added++;
	endfunction

	initial begin
		logic [47:0] ramp;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [2:0] fmt_v;
		logic [2:0] rule_v;

		// DXT5 codes 0..7 twice over the sixteen pixels
		for (int k = 0; k < 16; k++)
			ramp[3 * k +: 3] = k[2:0];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Plain DXT1, restriction bits all set and ignored.
		set_mode(FMT_DXT1, 3'd7);
		add_block({SEL_ALL, COL_FOUR}, '0);
		add_block({SEL_ALL, COL_THREE}, '0);
		add_block('0, '0);
		add_block(ONES, ONES);
		add_block({SEL_ALL, COL_MID}, '0);
		drain();

		// DXT1A without restriction: black entry is transparent in three-colour mode.
		set_mode(FMT_DXT1A, 3'd0);
		add_block({SEL_ALL, COL_FOUR}, '0);
		add_block({SEL_ALL, COL_THREE}, '0);
		drain();

		// DXT1A opaque-only, transparent-only, then both: each single bit refuses one block, both refuse every block.
		for (int m = 1; m <= 3; m++) begin
			set_mode(FMT_DXT1A, 3'(m));
			add_block({SEL_ALL, COL_FOUR}, '0);
			add_block({SEL_ALL, COL_THREE}, '0);
			drain();
		end

		// DXT3: every nibble value, and four-colour interpolation even when colour0 <= colour1.
		set_mode(FMT_DXT3, 3'd0);
		add_block(64'hFEDC_BA98_7654_3210, {SEL_ALL, COL_FOUR});
		add_block('0, {SEL_ALL, COL_THREE});
		add_block(ONES, {SEL_ALL, COL_MID});
		drain();

		// DXT3 colour-order restriction.
		set_mode(FMT_DXT3, 3'd4);
		add_block(64'h0123_4567_89AB_CDEF, {SEL_ALL, COL_THREE});
		add_block(64'h0123_4567_89AB_CDEF, {SEL_ALL, COL_FOUR});
		drain();

		// DXT5: 8-level ramp, 6-level ramp with fixed 0/255, equal and extreme endpoints.
		set_mode(FMT_DXT5, 3'd0);
		add_block({ramp, 8'd10, 8'd200}, {SEL_ALL, COL_MID});
		add_block({ramp, 8'd200, 8'd10}, {SEL_ALL, COL_MID});
		add_block({ramp, 8'd255, 8'd255}, {SEL_ALL, COL_MID});
		add_block({ramp, 8'd255, 8'd0}, {SEL_ALL, COL_THREE});
		add_block({ramp, 8'd0, 8'd255}, {SEL_ALL, COL_FOUR});
		drain();

		// DXT5 with alpha-order and colour-order restriction.
		set_mode(FMT_DXT5, 3'd5);
		add_block({ramp, 8'd10, 8'd200}, {SEL_ALL, COL_FOUR});
		add_block({ramp, 8'd200, 8'd10}, {SEL_ALL, COL_THREE});
		add_block({ramp, 8'd200, 8'd10}, {SEL_ALL, COL_FOUR});
		drain();

		// Random blocks under a new setting each phase. The first four walk the formats; later ones draw
		// at random, so some may write a format value with the unused top bit set.
		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				fmt_v = 3'(p);
				rule_v = p[0] ? 3'd7 : 3'd0;
			end else begin
				fmt_v = 3'($urandom_range(0, 7));
				rule_v = 3'($urandom_range(0, 7));
			end
			set_mode(fmt_v, rule_v);
			repeat (35) begin
				lo = {$urandom, $urandom};
				hi = {$urandom, $urandom};
				case ($urandom_range(0, 7))
				0: begin
					// equal endpoints: three-colour mode, refused under DXT3/DXT5 when the order bit is set
					lo[31:16] = lo[15:0];
					hi[31:16] = hi[15:0];
				end
				1: begin
					lo[15:8] = lo[7:0];	// equal alpha endpoints
				end
				2: begin
					lo[31:0] = $urandom_range(0, 1) ? COL_FOUR : COL_THREE;
					hi[31:0] = $urandom_range(0, 1) ? COL_FOUR : COL_THREE;
				end
				default: begin
				end
				endcase
				add_block(lo, hi);
			end
			drain();
		end

		$display("covered %0d blocks (%0d refused) across %0d register writes", blocks_in,
			blocks_refused, reg_writes);
		$display("checked %0d pixel items", pixels_checked);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
